[src/erm_pkg.sv]
// Package for the Euler rotation matrix core: CORDIC constants and word types.
package erm_pkg;

  localparam int unsigned CordicIters = 30;
  localparam int unsigned CordicW     = 34;
  localparam int unsigned ZW          = 32;
  localparam logic signed [CordicW-1:0] CordicGainQ30 = 34'sd652032874;

  typedef logic signed [CordicW-1:0] cord_t;
  typedef logic signed [ZW-1:0]      zang_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic zang_t atan_turn(input logic [4:0] i);
    zang_t r;
    r = '0;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/erm_cordic.sv]
// Pipelined CORDIC sine/cosine unit, one rotation stage per register stage.
module erm_cordic #(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output logic                   valid_o,
  output erm_pkg::cord_t         cos_o,
  output erm_pkg::cord_t         sin_o
);

  localparam int unsigned N = erm_pkg::CordicIters;

  erm_pkg::cord_t x_q [N+1];
  erm_pkg::cord_t y_q [N+1];
  erm_pkg::zang_t z_q [N+1];
  logic [1:0]     quad_q [N+1];
  logic [N:0]     vld_q;
  logic [31:0]    phase;

  // turn fraction in 32 bits
  assign phase = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};

  // stage 0: load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= erm_pkg::CordicGainQ30;
    y_q[0]    <= '0;
    z_q[0]    <= {2'b00, phase[29:0]};
    quad_q[0] <= phase[31:30];
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    erm_pkg::cord_t dx, dy;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      quad_q[i+1] <= quad_q[i];
      if (!z_q[i][erm_pkg::ZW-1]) begin
        x_q[i+1] <= x_q[i] - dy;
        y_q[i+1] <= y_q[i] + dx;
        z_q[i+1] <= z_q[i] - erm_pkg::atan_turn(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] + dy;
        y_q[i+1] <= y_q[i] - dx;
        z_q[i+1] <= z_q[i] + erm_pkg::atan_turn(5'(i));
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (quad_q[N])
      2'd0: begin cos_o = x_q[N];  sin_o = y_q[N];  end
      2'd1: begin cos_o = -y_q[N]; sin_o = x_q[N];  end
      2'd2: begin cos_o = -x_q[N]; sin_o = -y_q[N]; end
      default: begin cos_o = y_q[N]; sin_o = -x_q[N]; end
    endcase
  end

  assign valid_o = vld_q[N];

endmodule

[src/euler_rotation_matrix_core.sv]
// Top level: Euler-angle rotation matrix from three binary angles.
// Takes one angle triple per cycle (busy is always low). The nine Q2.14
// matrix entries reach the ports through the load stage, the 30-stage
// CORDIC pipeline, the fold/pre-product stage, two product stages and the
// rounding stage, with done_o high for a single cycle alongside them. The
// receiver cannot stall; there is no internal backpressure.
module euler_rotation_matrix_core #(
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ANGLE_WIDTH-1:0]    angle_x_i,
  input  logic [ANGLE_WIDTH-1:0]    angle_y_i,
  input  logic [ANGLE_WIDTH-1:0]    angle_z_i,
  output logic                      done_o,
  output logic signed [15:0]        m00_o,
  output logic signed [15:0]        m01_o,
  output logic signed [15:0]        m02_o,
  output logic signed [15:0]        m10_o,
  output logic signed [15:0]        m11_o,
  output logic signed [15:0]        m12_o,
  output logic signed [15:0]        m20_o,
  output logic signed [15:0]        m21_o,
  output logic signed [15:0]        m22_o
);

  localparam int unsigned PW = 72;
  localparam int unsigned SH = 60 - COEF_FRAC_BITS;

  logic vx, vy, vz, acc;
  erm_pkg::cord_t cx, sx, cy, sy, cz, sz;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  erm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cx (
    .clk_i, .rst_ni, .valid_i(acc), .angle_i(angle_x_i),
    .valid_o(vx), .cos_o(cx), .sin_o(sx));
  erm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cy (
    .clk_i, .rst_ni, .valid_i(acc), .angle_i(angle_y_i),
    .valid_o(vy), .cos_o(cy), .sin_o(sy));
  erm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cz (
    .clk_i, .rst_ni, .valid_i(acc), .angle_i(angle_z_i),
    .valid_o(vz), .cos_o(cz), .sin_o(sz));

  // stage A: register trig values, form cx*sy and sx*sy
  erm_pkg::cord_t cx_q, sx_q, cy_q, sy_q, cz_q, sz_q;
  logic signed [67:0] cxsy_q, sxsy_q;
  logic va_q;

  always_ff @(posedge clk_i) begin
    cx_q <= cx; sx_q <= sx; cy_q <= cy; sy_q <= sy; cz_q <= cz; sz_q <= sz;
    cxsy_q <= cx * sy;
    sxsy_q <= sx * sy;
  end

  // stage B: round the pre-products to Q30, form the plain products
  erm_pkg::cord_t cxsy_r, sxsy_r;
  logic signed [67:0] cxsy_rnd, sxsy_rnd;
  assign cxsy_rnd = (cxsy_q + (68'sd1 <<< 29)) >>> 30;
  assign sxsy_rnd = (sxsy_q + (68'sd1 <<< 29)) >>> 30;
  assign cxsy_r = erm_pkg::cord_t'(cxsy_rnd);
  assign sxsy_r = erm_pkg::cord_t'(sxsy_rnd);

  logic signed [PW-1:0] p00_q, p01_q, p02_q, p12_q, p22_q;
  logic signed [PW-1:0] sxcz_q, cxsz_q, cxcz_q, sxsz_q;
  erm_pkg::cord_t cxsyr_q, sxsyr_q, czb_q, szb_q;
  logic vb_q;

  always_ff @(posedge clk_i) begin
    p00_q   <= PW'(cy_q * cz_q);
    p01_q   <= -PW'(cy_q * sz_q);
    p02_q   <= PW'(sy_q) <<< 30;
    p12_q   <= -PW'(sx_q * cy_q);
    p22_q   <= PW'(cx_q * cy_q);
    sxcz_q  <= PW'(sx_q * cz_q);
    cxsz_q  <= PW'(cx_q * sz_q);
    cxcz_q  <= PW'(cx_q * cz_q);
    sxsz_q  <= PW'(sx_q * sz_q);
    cxsyr_q <= cxsy_r;
    sxsyr_q <= sxsy_r;
    czb_q   <= cz_q;
    szb_q   <= sz_q;
  end

  // stage C: second-level products and sums
  logic signed [PW-1:0] e_q [9];
  logic vc_q;

  always_ff @(posedge clk_i) begin
    e_q[0] <= p00_q;
    e_q[1] <= p01_q;
    e_q[2] <= p02_q;
    e_q[3] <= PW'(sxsyr_q * czb_q) + cxsz_q;
    e_q[4] <= cxcz_q - PW'(sxsyr_q * szb_q);
    e_q[5] <= p12_q;
    e_q[6] <= sxsz_q - PW'(cxsyr_q * czb_q);
    e_q[7] <= PW'(cxsyr_q * szb_q) + sxcz_q;
    e_q[8] <= p22_q;
  end

  // stage D: round and saturate to +/-1
  logic signed [15:0] m_q [9];
  for (genvar k = 0; k < 9; k++) begin : g_out
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] lim;
    assign lim = PW'(1) <<< COEF_FRAC_BITS;
    assign r   = (e_q[k] + (PW'(1) <<< (SH - 1))) >>> SH;
    always_ff @(posedge clk_i) begin
      if (r > lim) begin
        m_q[k] <= 16'(lim);
      end else if (r < -lim) begin
        m_q[k] <= 16'(-lim);
      end else begin
        m_q[k] <= 16'(r);
      end
    end
  end

  // valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      va_q   <= vx & vy & vz;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      done_o <= vc_q;
    end
  end

  assign m00_o = m_q[0];
  assign m01_o = m_q[1];
  assign m02_o = m_q[2];
  assign m10_o = m_q[3];
  assign m11_o = m_q[4];
  assign m12_o = m_q[5];
  assign m20_o = m_q[6];
  assign m21_o = m_q[7];
  assign m22_o = m_q[8];

`ifndef NO_ASSERTIONS
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx == vy) && (vy == vz)) else $error("CORDIC lanes out of step");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |=> done_o) else $error("result word lost");
  a_m22_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (m22_o <= 16'sd16384) && (m22_o >= -16'sd16384))
    else $error("entry beyond unity");
`endif

endmodule
